// ----- src/ngga_pkg.sv -----
package ngga_pkg;

	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_LF     = 8'h0a;
	localparam logic [7:0] CHAR_STAR   = 8'h2a;
	localparam logic [7:0] CHAR_G      = 8'h47;
	localparam logic [7:0] CHAR_P      = 8'h50;
	localparam logic [7:0] CHAR_N      = 8'h4e;
	localparam logic [7:0] CHAR_A      = 8'h41;
	localparam logic [7:0] HEADER_LEN  = 8'd6;

	localparam logic [7:0] BLANK_LIMIT_RST = 8'd32;
	localparam logic [7:0] MAX_LENGTH_RST  = 8'd127;

	typedef enum logic [0:0] {
		REG_BLANK_LIMIT = 1'b0,
		REG_MAX_LENGTH  = 1'b1
	} reg_idx_t;

	typedef enum logic [4:0] {
		PH_IDLE   = 5'b00001,
		PH_HEADER = 5'b00010,
		PH_DATA   = 5'b00100,
		PH_CK1    = 5'b01000,
		PH_CK2    = 5'b10000
	} phase_t;

	typedef struct packed {
		logic in_sentence;
		logic sentence_start;
		logic sentence_end;
		logic discard;
		logic no_data;
		logic overflow;
	} tag_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] len;
		logic [7:0] blank;
	} fstate_t;

endpackage

// ----- src/ngga_step.sv -----
module ngga_step (
	input  ngga_pkg::fstate_t cur,
	input  logic [7:0]        rx,
	input  logic [7:0]        blank_limit,
	input  logic [7:0]        max_length,
	output ngga_pkg::fstate_t nxt,
	output ngga_pkg::tag_t    tag
);
	import ngga_pkg::*;

	logic [8:0] len_p1;
	logic       acc_ok;
	logic       idle_acc_ok;
	logic [7:0] blank_inc;
	logic       blank_hit;
	logic       is_lf;
	logic       is_letter;
	fstate_t    idle_s;
	tag_t       idle_t;
	fstate_t    data_s;
	tag_t       data_t;

	assign len_p1      = {1'b0, cur.len} + 9'd1;
	assign acc_ok      = len_p1 <= {1'b0, max_length};
	assign idle_acc_ok = max_length != 8'd0;
	assign blank_inc   = (cur.blank == 8'hff) ? cur.blank : cur.blank + 8'd1;
	assign blank_hit   = blank_inc >= blank_limit;
	assign is_lf       = rx == CHAR_LF;
	assign is_letter   = rx == CHAR_G || rx == CHAR_P || rx == CHAR_N || rx == CHAR_A;

	// byte seen while idle; candidate length is zero, or one for an accepted dollar
	always_comb begin
		idle_s       = '{phase: PH_IDLE, len: 8'd0, blank: 8'd0};
		idle_t       = '0;
		if (is_lf) begin
			idle_s.blank   = blank_hit ? 8'd0 : blank_inc;
			idle_t.no_data = blank_hit;
		end else if (rx == CHAR_DOLLAR) begin
			if (idle_acc_ok) begin
				idle_s.phase          = PH_HEADER;
				idle_s.len            = 8'd1;
				idle_t.in_sentence    = 1'b1;
				idle_t.sentence_start = 1'b1;
			end else begin
				idle_t.overflow = 1'b1;
				idle_t.discard  = 1'b1;
			end
		end
	end

	// byte seen in the data part
	always_comb begin
		data_s = '{phase: PH_DATA, len: cur.len, blank: 8'd0};
		data_t = '0;
		if (is_lf) begin
			data_s.blank   = blank_hit ? 8'd0 : blank_inc;
			data_t.no_data = blank_hit;
			if (blank_hit) begin
				data_t.discard = 1'b1;
				data_s.phase   = PH_IDLE;
				data_s.len     = 8'd0;
			end
		end else if (acc_ok) begin
			data_s.len         = len_p1[7:0];
			data_t.in_sentence = 1'b1;
			if (rx == CHAR_STAR) begin
				data_s.phase = PH_CK1;
			end
		end else begin
			data_t.overflow = 1'b1;
			data_t.discard  = 1'b1;
			data_s.phase    = PH_IDLE;
			data_s.len      = 8'd0;
		end
	end

	always_comb begin
		nxt = cur;
		tag = '0;
		unique case (cur.phase)
			PH_HEADER: begin
				if (is_letter) begin
					nxt.blank = 8'd0;
					if (acc_ok) begin
						nxt.len         = len_p1[7:0];
						tag.in_sentence = 1'b1;
					end else begin
						tag.overflow = 1'b1;
						tag.discard  = 1'b1;
						nxt.phase    = PH_IDLE;
						nxt.len      = 8'd0;
					end
				end else if (cur.len >= HEADER_LEN) begin
					nxt = data_s;
					tag = data_t;
				end else begin
					nxt         = idle_s;
					tag         = idle_t;
					tag.discard = 1'b1;
				end
			end
			PH_DATA: begin
				nxt = data_s;
				tag = data_t;
			end
			PH_CK1, PH_CK2: begin
				nxt.blank = is_lf ? cur.blank : 8'd0;
				if (acc_ok) begin
					tag.in_sentence = 1'b1;
					if (cur.phase == PH_CK1) begin
						nxt.phase = PH_CK2;
						nxt.len   = len_p1[7:0];
					end else begin
						tag.sentence_end = 1'b1;
						nxt.phase        = PH_IDLE;
						nxt.len          = 8'd0;
					end
				end else begin
					tag.overflow = 1'b1;
					tag.discard  = 1'b1;
					nxt.phase    = PH_IDLE;
					nxt.len      = 8'd0;
				end
			end
			default: begin
				nxt = idle_s;
				tag = idle_t;
			end
		endcase
	end

endmodule

// ----- src/nmea_gga_sentence_extractor.sv -----
// NMEA GGA sentence extractor.
// Input channel: byte_valid / byte_stall carry rx_byte, one receiver byte per
// request. Output channel: tag_valid / tag_stall carry the same byte as
// out_byte plus its tags: in_sentence, sentence_start, sentence_end, discard,
// no_data and overflow. Every input byte yields exactly one output request.
// Configuration: cfg_we writes cfg_data into blank_limit (index 0) or
// max_length (index 1); write only while no byte is in flight.
// Path: an accepted byte passes through the input register and then the result
// register before it is presented at the output.
// Throughput: one byte per cycle while tag_stall is low. The framing state
// (phase, length, line-feed count) is updated by a single pass of compare
// logic from the input register into the result register.
// Stall: when tag_stall holds the result register, the input register still
// drains into it as soon as it frees up; byte_stall rises only when both
// registers are full and the output is stalled.
// Reset: arst_n clears both valids, returns the framer to idle with zero
// counts, and restores blank_limit to 32 and max_length to 127.
module nmea_gga_sentence_extractor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] rx_byte,
	output logic       tag_valid,
	input  logic       tag_stall,
	output logic [7:0] out_byte,
	output logic       in_sentence,
	output logic       sentence_start,
	output logic       sentence_end,
	output logic       discard,
	output logic       no_data,
	output logic       overflow
);
	import ngga_pkg::*;

	logic [7:0] blank_limit_q;
	logic [7:0] max_length_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	logic [7:0] byte_s2;
	tag_t       tag_s2;
	fstate_t    state_q;
	fstate_t    state_nxt;
	tag_t       tag_nxt;
	logic       advance;
	logic       take;

	// move s1 into s2 whenever the result register is empty or being drained
	assign advance    = valid_s1 && (!valid_s2 || !tag_stall);
	assign byte_stall = valid_s1 && !advance;
	assign take       = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_limit_q <= BLANK_LIMIT_RST;
			max_length_q  <= MAX_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_BLANK_LIMIT: blank_limit_q <= cfg_data;
				REG_MAX_LENGTH:  max_length_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register: hold the request until the step logic consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= rx_byte;
		end
	end

	ngga_step u_step (
		.cur         (state_q),
		.rx          (byte_s1),
		.blank_limit (blank_limit_q),
		.max_length  (max_length_q),
		.nxt         (state_nxt),
		.tag         (tag_nxt)
	);

	// framing state advances only with a byte that moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, len: 8'd0, blank: 8'd0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!tag_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_s2 <= byte_s1;
			tag_s2  <= tag_nxt;
		end
	end

	assign tag_valid      = valid_s2;
	assign out_byte       = byte_s2;
	assign in_sentence    = tag_s2.in_sentence;
	assign sentence_start = tag_s2.sentence_start;
	assign sentence_end   = tag_s2.sentence_end;
	assign discard        = tag_s2.discard;
	assign no_data        = tag_s2.no_data;
	assign overflow       = tag_s2.overflow;

	// an aborted byte is never part of the candidate
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && tag_s2.overflow |-> tag_s2.discard && !tag_s2.in_sentence)
		else $error("overflow without discard or with byte accepted");

	// a start tag only ever marks the dollar sign, and the dollar is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && tag_s2.sentence_start |-> byte_s2 == CHAR_DOLLAR && tag_s2.in_sentence)
		else $error("sentence_start on a byte that is not an accepted dollar");

	// a closing checksum character returns the framer to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && tag_nxt.sentence_end |=> state_q.phase == PH_IDLE && state_q.len == 8'd0)
		else $error("framer not idle after sentence end");

	// no_data always clears the line-feed run
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && tag_nxt.no_data |=> state_q.blank == 8'd0)
		else $error("line-feed count not cleared after no_data");

	// the framing state moves only together with a byte
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("framing state changed without a byte");

endmodule
